>>> rtl/core/psu_pkg.sv
// ============================================================================
// psu_pkg: shared types and constants of the prime sum unit
// Holds the result width, the saturation value and the transaction record
// that carries a finished sum from the sequencer to the output stage.
// ============================================================================
package psu_pkg;

    // Width of the returned sum and its saturation value.
    localparam int unsigned SUM_W = 28;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Width of the limit field on the input channel.
    localparam int unsigned LIMIT_W = 16;

    // Finished sum, presented by the sequencer until the output stage takes it.
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] total;
    } psu_done_t;

endpackage

>>> rtl/core/psu_sieve_ram.sv
// ============================================================================
// psu_sieve_ram: composite flag memory of the sieve
// One flag per number, one write port and one read port, read data registered
// so that a read returns its flag in the cycle after the address is given.
// ============================================================================
module psu_sieve_ram #(
    parameter int unsigned ADDR_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data
);

    logic mem_array [2**ADDR_W];
    logic rd_data_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/psu_seq.sv
// ============================================================================
// psu_seq: sieve sequencer of the prime sum unit
// Clears the flag memory once after reset, then for each limit scans the
// candidates in order, adds each prime and crosses out its multiples from
// its square upward. Each scanned flag is written back to zero, so the
// memory is clean again when the sum is finished.
// ============================================================================
module psu_seq
    import psu_pkg::*;
#(
    parameter int unsigned LIMIT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [LIMIT_W-1:0] limit,
    output psu_done_t          done,
    input  logic               done_ack
);

    localparam int unsigned LB = LIMIT_BITS;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_CROSS = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [LB-1:0]    clr_reg, clr_next;
    logic [LB-1:0]    lim_reg, lim_next;
    logic [LB-1:0]    p_reg, p_next;
    logic [2*LB-1:0]  sq_reg, sq_next;
    logic [LB:0]      m_reg, m_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic             wr_en, wr_data, rd_en, rd_data;
    logic [LB-1:0]    wr_addr, rd_addr;

    logic [LB-1:0]    lim_in;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_sat;
    logic [LB:0]      m_step;
    logic [2*LB-1:0]  sq_step;
    logic             is_prime, need_cross, is_last;

    psu_sieve_ram #(
        .ADDR_W (LB)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Datapath terms used by the scan and cross-out steps.
    always_comb
    begin
        lim_in     = LB'(limit);
        sum_add    = {1'b0, sum_reg} + (SUM_W+1)'(p_reg);
        sum_sat    = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        m_step     = m_reg + (LB+1)'(p_reg);
        sq_step    = sq_reg + {{(LB-1){1'b0}}, p_reg, 1'b1};
        is_prime   = !rd_data;
        need_cross = sq_reg <= (2*LB)'(lim_reg);
        is_last    = p_reg == lim_reg;
    end

    // Sequencer next state, memory accesses and accumulation.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        lim_next   = lim_reg;
        p_next     = p_reg;
        sq_next    = sq_reg;
        m_next     = m_reg;
        sum_next   = sum_reg;
        wr_en      = 1'b0;
        wr_addr    = p_reg;
        wr_data    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = p_reg + LB'(1);
        in_stall   = 1'b1;
        done.valid = 1'b0;
        done.total = sum_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + LB'(1);
                if (clr_reg == {LB{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    lim_next = lim_in;
                    sum_next = '0;
                    if (lim_in < LB'(2))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        p_next     = LB'(2);
                        sq_next    = (2*LB)'(4);
                        rd_en      = 1'b1;
                        rd_addr    = LB'(2);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Flag of p is in the read register; clear it behind the scan
                // and fetch the next candidate, which no cross-out can reach.
                wr_en   = 1'b1;
                wr_addr = p_reg;
                wr_data = 1'b0;
                rd_en   = !is_last;
                if (is_prime)
                begin
                    sum_next = sum_sat;
                end
                if (is_prime && need_cross)
                begin
                    m_next     = sq_reg[LB:0];
                    state_next = ST_CROSS;
                end
                else if (is_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    p_next  = p_reg + LB'(1);
                    sq_next = sq_step;
                end
            end
            ST_CROSS:
            begin
                wr_en   = 1'b1;
                wr_addr = m_reg[LB-1:0];
                wr_data = 1'b1;
                m_next  = m_step;
                if (m_step > {1'b0, lim_reg})
                begin
                    p_next     = p_reg + LB'(1);
                    sq_next    = sq_step;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                done.valid = 1'b1;
                if (done_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
        p_reg   <= p_next;
        sq_reg  <= sq_next;
        m_reg   <= m_next;
        sum_reg <= sum_next;
    end

endmodule

>>> rtl/core/prime_sum_up_to_limit_unit.sv
// ============================================================================
// prime_sum_up_to_limit_unit: sum of all primes up to a given limit
// Top level: sieve sequencer with its flag memory and the output register.
// ============================================================================
// Usage:
// The input channel (limit_valid, limit_stall, limit) takes one limit per
// transaction; only its low LIMIT_BITS bits are used. The output channel
// (result_valid, result_stall, prime_total) returns one sum per limit, in
// order, saturating at 2^28-1. Limits 0 and 1 give a sum of 0.
// The single flag memory sets the pace: the sequencer handles each scanned
// candidate and each multiple crossed out as a step of its own, and limits
// below 2 go from the idle state straight to the finished one.
// One transaction is worked on at a time; the next limit is taken in the
// cycle after the sum has moved to the output register.
// After reset the flag memory is cleared over all 2^LIMIT_BITS addresses,
// with limit_stall high. While the receiver stalls a pending result,
// prime_total and result_valid hold; a finished sum waits in the sequencer
// until the output register frees up, and no new limit is taken meanwhile.
// ============================================================================
module prime_sum_up_to_limit_unit
    import psu_pkg::*;
#(
    parameter int unsigned LIMIT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               limit_valid,
    output logic               limit_stall,
    input  logic [LIMIT_W-1:0] limit,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [SUM_W-1:0]   prime_total
);

    psu_done_t        done;
    logic             done_ack;
    logic             result_valid_reg, result_valid_next;
    logic [SUM_W-1:0] prime_total_reg, prime_total_next;

    psu_seq #(
        .LIMIT_BITS (LIMIT_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (limit_valid),
        .in_stall (limit_stall),
        .limit    (limit),
        .done     (done),
        .done_ack (done_ack)
    );

    // Output register loads when empty or when its transaction completes.
    always_comb
    begin
        done_ack          = !result_valid_reg || !result_stall;
        result_valid_next = result_valid_reg && result_stall;
        prime_total_next  = prime_total_reg;
        if (done.valid && done_ack)
        begin
            result_valid_next = 1'b1;
            prime_total_next  = done.total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_total_reg <= prime_total_next;
    end

    assign result_valid = result_valid_reg;
    assign prime_total  = prime_total_reg;

endmodule
